// ===== hw/rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W = 20;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;
    localparam int DEC_MAX = 7;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_NINE  = 6'd57;
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 20'd838861;
    localparam int                 RECIP_SHIFT = 23;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               too_large;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    function automatic logic [63:0] dec_limit(input int digits);
        logic [63:0] lim;
        lim = 64'd1;
        for (int i = 0; i < digits; i++) begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

endpackage

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit
// Turns 20-bit unsigned values into streams of decimal ASCII characters.
// ----------------------------------------------------------------------------
// Each value written with push comes out as its decimal digits in ASCII, most
// significant first and without leading zeros, one beat per character, with
// last set on the final beat; zero gives a single '0', and a value above the
// MAX_DIGITS limit gives one beat with too_large set and a character of 0.
// A value is loaded into the converter, then its digits are divided off one a
// cycle through the single reciprocal multiplier, then the characters are sent
// from the output register one a cycle, holding while that register is full
// and not popped. An oversized value skips the divide step. A two-entry queue
// in front of the converter takes further values while it is busy.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [b2da_pkg::VALUE_W-1:0] i_value,
    output logic                         empty,
    input  logic                         pop,
    output logic [b2da_pkg::CHAR_W-1:0]  o_ascii_char,
    output logic                         o_last,
    output logic                         o_too_large
);
    import b2da_pkg::*;

    t_job job;
    logic job_valid;
    logic job_ready;

    b2da_front #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_value     (i_value),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready)
    );

    b2da_back #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_job_valid  (job_valid),
        .o_job_ready  (job_ready),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last),
        .o_too_large  (o_too_large)
    );

endmodule

// ===== hw/rtl/b2da_front.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII front end
// Accepts values, flags those beyond the digit limit and queues them.
// ----------------------------------------------------------------------------
module b2da_front #(
    parameter int MAX_DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [b2da_pkg::VALUE_W-1:0] i_value,
    output b2da_pkg::t_job               o_job,
    output logic                         o_job_valid,
    input  logic                         i_job_ready
);
    import b2da_pkg::*;

    localparam logic [63:0] LIMIT = dec_limit(MAX_DIGITS);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              wr_en;
    logic              rd_en;
    t_job              job_in;

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = o_job_valid && i_job_ready;

    always_comb begin
        job_in.value     = i_value;
        job_in.too_large = ({{(64-VALUE_W){1'b0}}, i_value} > LIMIT);
    end

    always_comb begin
        unique case ({wr_en, rd_en})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= job_in;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("Queue count exceeds its depth.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QDEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Queue pointers disagree with the count.");

endmodule

// ===== hw/rtl/b2da_back.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII back end
// Splits a value into decimal digits and sends them out as characters.
// ----------------------------------------------------------------------------
module b2da_back #(
    parameter int MAX_DIGITS = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  b2da_pkg::t_job              i_job,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [b2da_pkg::CHAR_W-1:0] o_ascii_char,
    output logic                        o_last,
    output logic                        o_too_large
);
    import b2da_pkg::*;

    localparam int DIG_N = (MAX_DIGITS < DEC_MAX) ? MAX_DIGITS : DEC_MAX;
    localparam int CNT_W = $clog2(DIG_N + 1);
    localparam int IDX_W = (DIG_N > 1) ? $clog2(DIG_N) : 1;

    t_state             r_state;
    t_state             n_state;
    logic [VALUE_W-1:0] r_work;
    logic [VALUE_W-1:0] n_work;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_err;
    logic               n_err;
    logic [DIGIT_W-1:0] r_digits [DIG_N];
    logic               dig_we;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [CHAR_W-1:0]  n_out_char;
    logic               r_out_last;
    logic               n_out_last;
    logic               r_out_tl;
    logic               n_out_tl;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [VALUE_W-1:0]   rem_full;
    logic [DIGIT_W-1:0]   rem;
    logic [CNT_W-1:0]     cnt_m1;
    logic [DIGIT_W-1:0]   rd_digit;
    logic                 out_free;

    assign prod     = (2*VALUE_W)'(r_work) * (2*VALUE_W)'(RECIP_TEN);
    assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = r_work - quot_x10;
    assign rem      = rem_full[DIGIT_W-1:0];
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign rd_digit = r_digits[cnt_m1[IDX_W-1:0]];
    assign out_free = !r_out_valid || i_pop;

    assign o_empty      = !r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_last       = r_out_last;
    assign o_too_large  = r_out_tl;

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_cnt       = r_cnt;
        n_err       = r_err;
        dig_we      = 1'b0;
        o_job_ready = 1'b0;
        n_out_valid = r_out_valid && !i_pop;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_tl    = r_out_tl;
        unique case (r_state)
            ST_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_work = i_job.value;
                    n_err  = i_job.too_large;
                    if (i_job.too_large) begin
                        n_cnt   = CNT_W'(1);
                        n_state = ST_EMIT;
                    end else begin
                        n_cnt   = '0;
                        n_state = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE: begin
                dig_we = 1'b1;
                n_work = quot;
                n_cnt  = r_cnt + CNT_W'(1);
                if (quot == '0 || r_cnt == CNT_W'(DIG_N - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_err ? '0 : (ASCII_ZERO + CHAR_W'(rd_digit));
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_out_tl    = r_err;
                    n_cnt       = cnt_m1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_tl   <= n_out_tl;
        if (dig_we) begin
            r_digits[r_cnt[IDX_W-1:0]] <= rem;
        end
    end

    a_divide_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_cnt < CNT_W'(DIG_N)))
        else $error("Digit buffer overrun while dividing.");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("Emitting with no digits left.");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tl) |-> (r_out_last && r_out_char == '0))
        else $error("Error beat is malformed.");

    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_tl) |-> (r_out_char >= ASCII_ZERO && r_out_char <= ASCII_NINE))
        else $error("Character beat is not a decimal digit.");

endmodule

// ===== dv/binary_to_decimal_ascii_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit testbench
// Pushes 20-bit values into the converter and checks every character beat
// against a tabled or digit-by-digit prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit_tb;
    import b2da_pkg::*;

    localparam int MAX_DIGITS   = 6;
    localparam int RANDOM_ITEMS = 350;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              too_large;
    } t_char_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_char_beat         beat;
    } t_value_row;

    localparam t_char_beat NO_BEAT    = '{'0, 1'b0, 1'b0};
    localparam t_char_beat ERROR_BEAT = '{'0, 1'b1, 1'b1};

    localparam t_value_row VALUE_ROWS[20] = '{
        '{20'd0,       1'b1, '{ASCII_ZERO, 1'b1, 1'b0}},
        '{20'd1,       1'b1, '{ASCII_ZERO + 6'd1, 1'b1, 1'b0}},
        '{20'd9,       1'b1, '{ASCII_NINE, 1'b1, 1'b0}},
        '{20'd1000000, 1'b1, ERROR_BEAT},
        '{20'd1048575, 1'b1, ERROR_BEAT},
        '{20'd1000001, 1'b1, ERROR_BEAT},
        '{20'd999999,  1'b0, NO_BEAT},
        '{20'd10,      1'b0, NO_BEAT},
        '{20'd99,      1'b0, NO_BEAT},
        '{20'd100,     1'b0, NO_BEAT},
        '{20'd999,     1'b0, NO_BEAT},
        '{20'd1000,    1'b0, NO_BEAT},
        '{20'd9999,    1'b0, NO_BEAT},
        '{20'd10000,   1'b0, NO_BEAT},
        '{20'd99999,   1'b0, NO_BEAT},
        '{20'd100000,  1'b0, NO_BEAT},
        '{20'd123456,  1'b0, NO_BEAT},
        '{20'd524288,  1'b0, NO_BEAT},
        '{20'd349525,  1'b0, NO_BEAT},
        '{20'd699050,  1'b0, NO_BEAT}
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               pop     = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               full;
    logic               empty;
    logic [CHAR_W-1:0]  o_ascii_char;
    logic               o_last;
    logic               o_too_large;

    t_char_beat pending_chars[$];
    int         mismatch_count = 0;
    int         stall_cycles   = 0;
    bit         quiet          = 1'b0;

    always #10 i_clk = ~i_clk;

    binary_to_decimal_ascii_unit #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .o_ascii_char(o_ascii_char),
        .o_last      (o_last),
        .o_too_large (o_too_large)
    );

    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [63:0] limit;
        logic [63:0] rest;
        int          digits[$];
        limit = 64'd1;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            limit = limit * 64'd10;
        end
        if (value > limit - 64'd1) begin
            pending_chars.push_back(ERROR_BEAT);
            return;
        end
        rest = value;
        do begin
            digits.push_front(int'(rest % 64'd10));
            rest = rest / 64'd10;
        end while (rest != 64'd0);
        foreach (digits[k]) begin
            pending_chars.push_back('{ASCII_ZERO + CHAR_W'(digits[k]),
                                      k == digits.size() - 1, 1'b0});
        end
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (full);
    endtask

    initial begin
        int                 kind;
        int                 n;
        int unsigned        pow;
        logic [VALUE_W-1:0] value;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < $size(VALUE_ROWS); r++) begin
            send_value(VALUE_ROWS[r].value);
            if (VALUE_ROWS[r].typed) begin
                pending_chars.push_back(VALUE_ROWS[r].beat);
            end else begin
                predict_digits(VALUE_ROWS[r].value);
            end
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 9);
            n    = $urandom_range(1, MAX_DIGITS);
            pow  = 1;
            repeat (n) pow = pow * 10;
            case (kind)
                0: begin
                    value = VALUE_W'($urandom_range((1 << VALUE_W) - 1, 10 ** MAX_DIGITS));
                end
                1: begin
                    value = VALUE_W'($urandom);
                end
                2: begin
                    value = VALUE_W'(pow - $urandom_range(0, 1));
                end
                default: begin
                    value = VALUE_W'($urandom_range(pow - 1, pow / 10));
                end
            endcase
            send_value(value);
            predict_digits(value);
        end
        push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS binary_to_decimal_ascii_unit");
        end else begin
            $display("FAIL binary_to_decimal_ascii_unit");
        end
        $finish;
    end

    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat char %0d last %0b too_large %0b",
                                              o_ascii_char, o_last, o_too_large));
                end else begin
                    want = pending_chars.pop_front();
                    if (o_ascii_char !== want.ch) begin
                        report_mismatch($sformatf("ascii_char got %0d want %0d",
                                                  o_ascii_char, want.ch));
                    end
                    if (o_last !== want.last) begin
                        report_mismatch($sformatf("last got %0b want %0b", o_last, want.last));
                    end
                    if (o_too_large !== want.too_large) begin
                        report_mismatch($sformatf("too_large got %0b want %0b",
                                                  o_too_large, want.too_large));
                    end
                end
            end
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout with %0d beats outstanding", $time, pending_chars.size());
                $display("FAIL binary_to_decimal_ascii_unit");
                $finish;
            end
        end
    end

endmodule
